// ===== src/sapc_pkg.sv =====
// shared constants, codes and control types for the syn/arp packet classifier
`timescale 1ns / 1ps
package sapc_pkg;

  // unique-source set geometry
  localparam int SET_DEPTH  = 64;
  localparam int SET_ADDR_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int COUNT_W    = $clog2(SET_DEPTH + 1);
  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(SET_DEPTH);

  // frame byte position
  localparam int OFFSET_W = 11;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 11'd2047;

  // header field values
  localparam logic [15:0] TYPE_ARP  = 16'h0806;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] OP_REPLY  = 16'd2;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [15:0] WATCHED_PORT_RESET = 16'd80;

  // packet class codes
  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_ARP   = 3'd1;
  localparam logic [2:0] CLS_SYN   = 3'd2;
  localparam logic [2:0] CLS_HTTP  = 3'd3;
  localparam logic [2:0] CLS_TCP   = 3'd4;

  typedef struct packed {
    logic take;         // byte channel ready
    logic search_step;  // walk the source set one entry
    logic emit;         // load result, update counters and set, clear frame
  } sapc_cmd_t;

  typedef struct packed {
    logic last_taken;   // final byte of a frame accepted this cycle
    logic is_syn;       // frame held in the capture registers is a pure syn
    logic search_done;  // set walk finished (hit or end of stored entries)
    logic out_free;     // result register can take a new result
  } sapc_status_t;

endpackage

// ===== src/sapc_if.sv =====
// byte and result channel interfaces
`timescale 1ns / 1ps
interface sapc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface sapc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  packet_class;
  logic        new_source;
  logic        set_full;
  logic        truncated;
  logic [31:0] arp_reply_count;
  logic [31:0] syn_count;
  logic [6:0]  unique_source_count;

  modport source (output valid, packet_class, new_source, set_full, truncated,
                  arp_reply_count, syn_count, unique_source_count, input ready);
  modport sink   (input valid, packet_class, new_source, set_full, truncated,
                  arp_reply_count, syn_count, unique_source_count, output ready);
endinterface

// ===== src/syn_arp_packet_classifier_core.sv =====
// top level of the syn/arp packet classifier
`timescale 1ns / 1ps
// Frame bytes enter on the frame channel (valid/ready), one byte per cycle,
// from the first destination MAC byte; last_byte marks the end of a frame.
// Each frame yields one request on the result channel: its class, the
// truncation flag, the source-set flags and the ARP reply, SYN and
// unique-source counts after that frame.
// Sequence: after the last byte is taken a non-SYN frame passes the check
// and emit states before its result is registered; a pure SYN walks the
// source set one entry a cycle between them, stopping early on a match.
// Throughput: one byte per cycle within a frame; after the last byte the
// frame channel drops ready until the result is in the output register.
// The result register holds one request; the next frame's bytes are taken
// while it waits, but its own result waits for the receiver.
// Reset (rst, synchronous) clears the counters, the capture state and the
// output register and sets the watched port to 80; the set needs no clear.
// cfg_we / cfg_wdata write the watched port; write it only while idle.
module syn_arp_packet_classifier_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  sapc_byte_if.sink     frame,
  sapc_result_if.source result
);
  import sapc_pkg::*;

  sapc_cmd_t    cmd;
  sapc_status_t status;

  sapc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  sapc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .frame     (frame),
    .result    (result)
  );

endmodule

// ===== src/sapc_ctrl.sv =====
// frame sequencer: capture, classify, set search and result hand-off
`timescale 1ns / 1ps
module sapc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  sapc_pkg::sapc_status_t status,
  output sapc_pkg::sapc_cmd_t    cmd
);
  import sapc_pkg::*;

  localparam logic [1:0] ST_CAPTURE = 2'd0;
  localparam logic [1:0] ST_CHECK   = 2'd1;
  localparam logic [1:0] ST_SEARCH  = 2'd2;
  localparam logic [1:0] ST_EMIT    = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CAPTURE: if (status.last_taken) state_next = ST_CHECK;
      ST_CHECK: begin
        if (status.is_syn) state_next = ST_SEARCH;
        else state_next = ST_EMIT;
      end
      ST_SEARCH: if (status.search_done) state_next = ST_EMIT;
      ST_EMIT: if (status.out_free) state_next = ST_CAPTURE;
      default: state_next = ST_CAPTURE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CAPTURE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd.take        = (state == ST_CAPTURE);
  assign cmd.search_step = (state == ST_SEARCH);
  assign cmd.emit        = (state == ST_EMIT) && status.out_free;

endmodule

// ===== src/sapc_datapath.sv =====
// header capture, classification, counters, source set and result register
`timescale 1ns / 1ps
module sapc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  sapc_pkg::sapc_cmd_t cmd,
  output sapc_pkg::sapc_status_t status,
  sapc_byte_if.sink           frame,
  sapc_result_if.source       result
);
  import sapc_pkg::*;

  logic [15:0]         watched_port;
  logic [OFFSET_W-1:0] byte_offset;
  logic [15:0]         frame_type;
  logic [15:0]         arp_opcode;
  logic [3:0]          ip_header_words;
  logic [7:0]          ip_protocol;
  logic [31:0]         source_address;
  logic [15:0]         tcp_destination;
  logic [5:0]          tcp_flag_bits;
  logic [31:0]         arp_total;
  logic [31:0]         syn_total;
  logic [COUNT_W-1:0]  unique_total;

  logic [31:0]         source_set [SET_DEPTH];
  logic [COUNT_W-1:0]  search_idx;
  logic [31:0]         rd_data;
  logic                rd_valid;
  logic                found;
  logic                hit_now;

  logic                take_byte;
  logic [OFFSET_W-1:0] tcp_base;
  logic [OFFSET_W-1:0] tcp_need;

  logic [2:0]          cls;
  logic                trunc;
  logic                syn;
  logic                store_new;
  logic                store_full;
  logic [31:0]         arp_next;
  logic [31:0]         syn_next;
  logic [COUNT_W-1:0]  unique_next;

  assign frame.ready = cmd.take;
  assign take_byte   = frame.valid && cmd.take;

  // tcp header start follows the captured ihl, which may be below five
  assign tcp_base = OFFSET_W'(14) + OFFSET_W'({ip_header_words, 2'b00});
  assign tcp_need = OFFSET_W'(28) + OFFSET_W'({ip_header_words, 2'b00});

  // byte_offset saturates at 2047, so it stands for the frame length here
  always_comb begin
    cls   = CLS_OTHER;
    trunc = 1'b0;
    syn   = 1'b0;
    if (byte_offset < OFFSET_W'(14)) begin
      trunc = 1'b1;
    end else if (frame_type == TYPE_ARP) begin
      if (byte_offset < OFFSET_W'(22)) trunc = 1'b1;
      else if (arp_opcode == OP_REPLY) cls = CLS_ARP;
    end else if (frame_type == TYPE_IPV4) begin
      if (byte_offset < OFFSET_W'(24)) begin
        trunc = 1'b1;
      end else if (ip_protocol == PROTO_TCP) begin
        if (byte_offset < tcp_need || byte_offset < OFFSET_W'(30)) begin
          trunc = 1'b1;
        end else if ((tcp_flag_bits & 6'h3D) == 6'h00 && tcp_flag_bits[1]) begin
          cls = CLS_SYN;
          syn = 1'b1;
        end else if (tcp_destination == watched_port) begin
          cls = CLS_HTTP;
        end else begin
          cls = CLS_TCP;
        end
      end
    end
  end

  assign hit_now    = rd_valid && (rd_data == source_address);
  assign store_new  = syn && !found && (unique_total < DEPTH_COUNT);
  assign store_full = syn && !found && !(unique_total < DEPTH_COUNT);

  assign arp_next    = (cls == CLS_ARP && arp_total != 32'hFFFF_FFFF) ? arp_total + 32'd1
                                                                       : arp_total;
  assign syn_next    = (syn && syn_total != 32'hFFFF_FFFF) ? syn_total + 32'd1 : syn_total;
  assign unique_next = store_new ? unique_total + COUNT_W'(1) : unique_total;

  assign status.last_taken  = take_byte && frame.last_byte;
  assign status.is_syn      = syn;
  assign status.search_done = hit_now || (!rd_valid && !(search_idx < unique_total));
  assign status.out_free    = !result.valid || result.ready;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      watched_port <= WATCHED_PORT_RESET;
    end else if (cfg_we) begin
      watched_port <= cfg_wdata;
    end
  end

  // header capture at fixed and ihl-relative offsets
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      byte_offset     <= '0;
      frame_type      <= '0;
      arp_opcode      <= '0;
      ip_header_words <= '0;
      ip_protocol     <= '0;
      source_address  <= '0;
      tcp_destination <= '0;
      tcp_flag_bits   <= '0;
    end else if (take_byte) begin
      if (byte_offset < OFFSET_MAX) byte_offset <= byte_offset + OFFSET_W'(1);
      if (byte_offset == OFFSET_W'(12)) frame_type[15:8] <= frame.data_byte;
      if (byte_offset == OFFSET_W'(13)) frame_type[7:0] <= frame.data_byte;
      if (byte_offset == OFFSET_W'(14)) ip_header_words <= frame.data_byte[3:0];
      if (byte_offset == OFFSET_W'(20)) arp_opcode[15:8] <= frame.data_byte;
      if (byte_offset == OFFSET_W'(21)) arp_opcode[7:0] <= frame.data_byte;
      if (byte_offset == OFFSET_W'(23)) ip_protocol <= frame.data_byte;
      if (byte_offset == OFFSET_W'(26)) source_address[31:24] <= frame.data_byte;
      if (byte_offset == OFFSET_W'(27)) source_address[23:16] <= frame.data_byte;
      if (byte_offset == OFFSET_W'(28)) source_address[15:8] <= frame.data_byte;
      if (byte_offset == OFFSET_W'(29)) source_address[7:0] <= frame.data_byte;
      if (byte_offset > OFFSET_W'(14)) begin
        if (byte_offset == tcp_base + OFFSET_W'(2)) tcp_destination[15:8] <= frame.data_byte;
        if (byte_offset == tcp_base + OFFSET_W'(3)) tcp_destination[7:0] <= frame.data_byte;
        if (byte_offset == tcp_base + OFFSET_W'(13)) tcp_flag_bits <= frame.data_byte[5:0];
      end
    end
  end

  // source set memory: one read per cycle during the walk, one write at emit
  always_ff @(posedge clk) begin
    if (cmd.search_step && search_idx < unique_total) begin
      rd_data <= source_set[search_idx[SET_ADDR_W-1:0]];
    end
    if (cmd.emit && store_new) begin
      source_set[unique_total[SET_ADDR_W-1:0]] <= source_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      search_idx <= '0;
      rd_valid   <= 1'b0;
      found      <= 1'b0;
    end else if (cmd.search_step) begin
      if (hit_now) found <= 1'b1;
      if (search_idx < unique_total) begin
        rd_valid   <= 1'b1;
        search_idx <= search_idx + COUNT_W'(1);
      end else begin
        rd_valid <= 1'b0;
      end
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      arp_total    <= '0;
      syn_total    <= '0;
      unique_total <= '0;
    end else if (cmd.emit) begin
      arp_total    <= arp_next;
      syn_total    <= syn_next;
      unique_total <= unique_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.packet_class        <= cls;
      result.new_source          <= store_new;
      result.set_full            <= store_full;
      result.truncated           <= trunc;
      result.arp_reply_count     <= arp_next;
      result.syn_count           <= syn_next;
      result.unique_source_count <= 7'(unique_next);
    end
  end

endmodule

// ===== dv/syn_arp_packet_classifier_core_tb.sv =====
// testbench for the syn/arp packet classifier: frame stimulus, result prediction and checking
`timescale 1ns / 1ps
module syn_arp_packet_classifier_core_tb;
  import sapc_pkg::*;

  localparam int STALL_LIMIT = 4000;

  localparam logic [5:0] FL_FIN = 6'h01;
  localparam logic [5:0] FL_SYN = 6'h02;
  localparam logic [5:0] FL_PSH = 6'h08;
  localparam logic [5:0] FL_ACK = 6'h10;
  localparam logic [5:0] FL_ALL = 6'h3F;

  localparam logic [31:0] SRC_A = 32'h0A00_0001;
  localparam logic [31:0] SRC_B = 32'hC0A8_0102;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef struct packed {
    logic [2:0]  cls;
    logic        fresh;
    logic        full;
    logic        trunc;
    logic [31:0] arp;
    logic [31:0] syn;
    logic [6:0]  uniq;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  sapc_byte_if   frame_ch ();
  sapc_result_if result_ch ();

  syn_arp_packet_classifier_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .frame     (frame_ch),
    .result    (result_ch)
  );

  always #5 clk = ~clk;

  // classifier state as predicted
  logic [15:0] port_watch;
  logic [10:0] hdr_pos;
  logic [15:0] cap_type;
  logic [15:0] cap_opcode;
  logic [3:0]  cap_ihl;
  logic [7:0]  cap_proto;
  logic [31:0] cap_src;
  logic [15:0] cap_dport;
  logic [5:0]  cap_flags;
  logic [31:0] arp_seen;
  logic [31:0] syn_seen;
  int          src_stored;
  logic [31:0] src_table [SET_DEPTH];

  verdict_t    verdict_q[$];
  frame_byte_t byte_queue[$];
  frame_byte_t next_byte;
  logic [7:0]  fbuf[];
  logic [31:0] syn_sources[$];

  int bytes_queued;
  int bytes_taken_cnt;
  int fail_count;
  int idle_cycles;
  int src_gap;
  int sink_gap;
  bit quiet;
  logic byte_taken;

  int frames_checked;
  int class_hits [5];
  int trunc_hits;
  int fresh_hits;
  int full_hits;

  task automatic clear_capture();
    hdr_pos    = '0;
    cap_type   = '0;
    cap_opcode = '0;
    cap_ihl    = '0;
    cap_proto  = '0;
    cap_src    = '0;
    cap_dport  = '0;
    cap_flags  = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    int       pos;
    int       flen;
    int       tcp_at;
    int       i;
    bit       found;
    verdict_t v;
    pos    = int'(hdr_pos);
    tcp_at = 14 + 4 * cap_ihl;
    if (pos == 12) cap_type[15:8] = b;
    if (pos == 13) cap_type[7:0] = b;
    if (pos == 14) cap_ihl = b[3:0];
    if (pos == 20) cap_opcode[15:8] = b;
    if (pos == 21) cap_opcode[7:0] = b;
    if (pos == 23) cap_proto = b;
    if (pos >= 26 && pos <= 29) cap_src[8 * (29 - pos) +: 8] = b;
    if (pos > 14) begin
      if (pos == tcp_at + 2) cap_dport[15:8] = b;
      if (pos == tcp_at + 3) cap_dport[7:0] = b;
      if (pos == tcp_at + 13) cap_flags = b[5:0];
    end
    if (hdr_pos < OFFSET_MAX) hdr_pos = hdr_pos + 11'd1;
    if (last) begin
      v     = '0;
      v.cls = CLS_OTHER;
      flen  = pos + 1;
      if (flen < 14) begin
        v.trunc = 1'b1;
      end else if (cap_type == TYPE_ARP) begin
        if (flen < 22) begin
          v.trunc = 1'b1;
        end else if (cap_opcode == OP_REPLY) begin
          v.cls = CLS_ARP;
          if (arp_seen != '1) arp_seen = arp_seen + 1;
        end
      end else if (cap_type == TYPE_IPV4) begin
        if (flen < 24) begin
          v.trunc = 1'b1;
        end else if (cap_proto == PROTO_TCP) begin
          if (flen < 28 + 4 * cap_ihl || flen < 30) begin
            v.trunc = 1'b1;
          end else if ((cap_flags & 6'h3D) == 6'h00 && cap_flags[1]) begin
            // pure syn wins over the watched port
            v.cls = CLS_SYN;
            if (syn_seen != '1) syn_seen = syn_seen + 1;
            found = 1'b0;
            for (i = 0; i < src_stored; i++)
              if (src_table[i] == cap_src) found = 1'b1;
            if (!found) begin
              if (src_stored >= SET_DEPTH) begin
                v.full = 1'b1;
              end else begin
                src_table[src_stored] = cap_src;
                src_stored++;
                v.fresh = 1'b1;
              end
            end
          end else if (cap_dport == port_watch) begin
            v.cls = CLS_HTTP;
          end else begin
            v.cls = CLS_TCP;
          end
        end
      end
      v.arp  = arp_seen;
      v.syn  = syn_seen;
      v.uniq = src_stored[6:0];
      verdict_q.push_back(v);
      clear_capture();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (verdict_q.size() == 0) begin
      $display("%0t: result with nothing expected, expected none, got class %0d",
               $time, result_ch.packet_class);
      fail_count++;
    end else begin
      want = verdict_q.pop_front();
      check_field("packet_class", 32'(want.cls), 32'(result_ch.packet_class));
      check_field("new_source", 32'(want.fresh), 32'(result_ch.new_source));
      check_field("set_full", 32'(want.full), 32'(result_ch.set_full));
      check_field("truncated", 32'(want.trunc), 32'(result_ch.truncated));
      check_field("arp_reply_count", want.arp, result_ch.arp_reply_count);
      check_field("syn_count", want.syn, result_ch.syn_count);
      check_field("unique_source_count", 32'(want.uniq),
                  32'(result_ch.unique_source_count));
      frames_checked++;
      if (want.cls <= CLS_TCP) class_hits[want.cls]++;
      trunc_hits += want.trunc;
      fresh_hits += want.fresh;
      full_hits  += want.full;
    end
  endtask

  // sample both channels, predict and check
  always @(posedge clk) begin
    if (rst) begin
      byte_taken  <= 1'b0;
      idle_cycles <= 0;
    end else begin
      byte_taken <= frame_ch.valid && frame_ch.ready;
      if (frame_ch.valid && frame_ch.ready) begin
        predict_byte(frame_ch.data_byte, frame_ch.last_byte);
        bytes_taken_cnt++;
      end
      if (result_ch.valid && result_ch.ready) check_verdict();
      if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!frame_ch.valid || byte_taken) begin
        if (src_gap > 0) begin
          frame_ch.valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (byte_queue.size() > 0) begin
          next_byte = byte_queue.pop_front();
          frame_ch.valid     <= 1'b1;
          frame_ch.data_byte <= next_byte.data;
          frame_ch.last_byte <= next_byte.last;
          if (!quiet && $urandom_range(0, 15) == 0) src_gap <= $urandom_range(1, 12);
        end else begin
          frame_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver with stall bursts
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      result_ch.ready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      result_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) sink_gap <= $urandom_range(1, 12);
    end
  end

  task automatic new_frame(input int len);
    fbuf = new[len];
    foreach (fbuf[i]) fbuf[i] = 8'($urandom);
  endtask

  task automatic put8(input int pos, input logic [7:0] v);
    if (pos < fbuf.size()) fbuf[pos] = v;
  endtask

  task automatic put16(input int pos, input logic [15:0] v);
    put8(pos, v[15:8]);
    put8(pos + 1, v[7:0]);
  endtask

  task automatic queue_frame();
    frame_byte_t fb;
    for (int i = 0; i < fbuf.size(); i++) begin
      fb.data = fbuf[i];
      fb.last = (i == fbuf.size() - 1);
      byte_queue.push_back(fb);
    end
    bytes_queued += fbuf.size();
  endtask

  function automatic int tcp_min_len(input logic [3:0] ihl);
    int m;
    m = 28 + 4 * ihl;
    return (m < 30) ? 30 : m;
  endfunction

  // flags go in last so they win where a short ip header overlaps the source
  task automatic tcp_frame(input int len, input logic [3:0] ihl, input logic [5:0] flags,
                           input logic [15:0] dport, input logic [31:0] src);
    int tcp_at;
    tcp_at = 14 + 4 * ihl;
    new_frame(len);
    put16(12, TYPE_IPV4);
    put8(14, {4'($urandom), ihl});
    put8(23, PROTO_TCP);
    put16(26, src[31:16]);
    put16(28, src[15:0]);
    put16(tcp_at + 2, dport);
    put8(tcp_at + 13, {2'($urandom), flags});
    queue_frame();
  endtask

  task automatic arp_frame(input int len, input logic [15:0] opcode);
    new_frame(len);
    put16(12, TYPE_ARP);
    put16(20, opcode);
    queue_frame();
  endtask

  task automatic ip_frame(input int len, input logic [7:0] proto);
    new_frame(len);
    put16(12, TYPE_IPV4);
    put8(23, proto);
    queue_frame();
  endtask

  task automatic eth_frame(input int len, input logic [15:0] etype);
    new_frame(len);
    put16(12, etype);
    queue_frame();
  endtask

  // mostly full-length frames, with some cut right at or below the minimum
  function automatic int pick_len(input int minimum);
    case ($urandom_range(0, 9))
      0: return $urandom_range(1, minimum - 1);
      1: return minimum - 1;
      2: return minimum;
      default: return minimum + $urandom_range(0, 24);
    endcase
  endfunction

  task automatic pick_source(output logic [31:0] addr);
    if (syn_sources.size() > 0 && $urandom_range(0, 1) == 0) begin
      addr = syn_sources[$urandom_range(0, syn_sources.size() - 1)];
    end else begin
      addr = $urandom;
      syn_sources.push_back(addr);
    end
  endtask

  task automatic random_mix(input int nbytes);
    int          goal;
    int          r;
    logic [3:0]  ihl;
    logic [5:0]  flags;
    logic [15:0] dport;
    logic [31:0] src;
    goal = bytes_queued + nbytes;
    while (bytes_queued < goal) begin
      r = $urandom_range(0, 19);
      if (r < 10) begin
        ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
        case ($urandom_range(0, 3))
          0, 1: flags = FL_SYN;
          2: flags = 6'($urandom) | FL_SYN;
          default: flags = 6'($urandom);
        endcase
        case ($urandom_range(0, 2))
          0: dport = port_watch;
          1: dport = port_watch + 16'd1;
          default: dport = 16'($urandom);
        endcase
        pick_source(src);
        tcp_frame(pick_len(tcp_min_len(ihl)), ihl, flags, dport, src);
      end else if (r < 13) begin
        arp_frame(pick_len(22), ($urandom_range(0, 1) == 0) ? OP_REPLY : 16'($urandom));
      end else if (r < 15) begin
        ip_frame(pick_len(24), 8'($urandom));
      end else if (r < 17) begin
        eth_frame(pick_len(14), 16'($urandom));
      end else begin
        new_frame($urandom_range(1, 40));
        queue_frame();
      end
    end
  endtask

  // short syn frames, mostly from new sources
  task automatic fill_set(input int count);
    logic [3:0]  ihl;
    logic [31:0] src;
    repeat (count) begin
      if (syn_sources.size() > 0 && $urandom_range(0, 4) == 0) begin
        src = syn_sources[$urandom_range(0, syn_sources.size() - 1)];
        ihl = 4'd5;
      end else begin
        src = $urandom;
        syn_sources.push_back(src);
        ihl = 4'($urandom_range(0, 5));
      end
      tcp_frame(tcp_min_len(ihl) + $urandom_range(0, 3), ihl, FL_SYN, 16'($urandom), src);
    end
  endtask

  task automatic directed_frames();
    logic [3:0] ihl;
    arp_frame(22, OP_REPLY);
    arp_frame(60, OP_REPLY);
    arp_frame(42, 16'h0001);
    arp_frame(21, OP_REPLY);
    arp_frame(60, 16'hFFFF);
    new_frame(1);
    queue_frame();
    eth_frame(13, 16'h86DD);
    eth_frame(14, 16'hFFFF);
    ip_frame(23, 8'h11);
    ip_frame(24, 8'h11);
    ip_frame(40, 8'hFF);
    tcp_frame(54, 4'd5, FL_SYN, 16'd1234, SRC_A);
    tcp_frame(54, 4'd5, FL_SYN, port_watch, SRC_A);
    tcp_frame(30, 4'd0, FL_SYN, 16'd0, SRC_B);
    tcp_frame(29, 4'd0, FL_SYN, 16'd0, SRC_B);
    tcp_frame(53, 4'd5, FL_ACK, port_watch, SRC_B);
    tcp_frame(88, 4'd15, FL_SYN, 16'hFFFF, 32'hFFFF_FFFF);
    tcp_frame(60, 4'd5, FL_SYN | FL_ACK, port_watch, SRC_A);
    tcp_frame(60, 4'd5, FL_PSH, port_watch, SRC_A);
    tcp_frame(60, 4'd5, FL_ALL, port_watch + 16'd1, SRC_B);
    tcp_frame(60, 4'd5, 6'h00, 16'hFFFF, 32'h0000_0000);
    tcp_frame(60, 4'd5, FL_FIN, port_watch, SRC_B);
    for (ihl = 4'd1; ihl <= 4'd4; ihl++)
      tcp_frame(tcp_min_len(ihl), ihl, FL_SYN, 16'($urandom), $urandom);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_taken_cnt != bytes_queued || verdict_q.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_port(input logic [15:0] v);
    cfg_wdata  <= v;
    cfg_we     <= 1'b1;
    port_watch = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    frame_ch.valid      = 1'b0;
    frame_ch.data_byte  = '0;
    frame_ch.last_byte  = 1'b0;
    result_ch.ready     = 1'b0;
    port_watch          = WATCHED_PORT_RESET;
    arp_seen            = '0;
    syn_seen            = '0;
    src_stored          = 0;
    bytes_queued        = 0;
    bytes_taken_cnt     = 0;
    fail_count          = 0;
    src_gap             = 0;
    sink_gap            = 0;
    quiet               = 1'b0;
    frames_checked      = 0;
    trunc_hits          = 0;
    fresh_hits          = 0;
    full_hits           = 0;
    foreach (class_hits[i]) class_hits[i] = 0;
    clear_capture();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(posedge clk);
    directed_frames();
    wait_idle();

    set_port(16'hFFFF);
    @(posedge clk);
    random_mix(60);
    wait_idle();

    set_port(16'h0000);
    @(posedge clk);
    fill_set(2);
    random_mix(30);
    wait_idle();

    set_port(16'($urandom));
    @(posedge clk);
    random_mix(40);
    wait_idle();

    set_port(WATCHED_PORT_RESET);
    @(posedge clk);
    quiet = 1'b1;
    random_mix(40);
    wait_idle();
    repeat (20) @(posedge clk);

    $display("%0d frames in %0d bytes: other %0d, arp reply %0d, syn %0d, http %0d, tcp %0d",
             frames_checked, bytes_queued, class_hits[0], class_hits[1], class_hits[2],
             class_hits[3], class_hits[4]);
    $display("truncated %0d, new sources %0d, set full %0d, sources stored %0d",
             trunc_hits, fresh_hits, full_hits, src_stored);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== syn_arp_packet_classifier_core.f =====
src/sapc_pkg.sv
src/sapc_if.sv
src/sapc_ctrl.sv
src/sapc_datapath.sv
src/syn_arp_packet_classifier_core.sv
dv/syn_arp_packet_classifier_core_tb.sv
